[hdl/object_id_map_with_frame_bitmaps_unit_assert.svh]
// assertion macros for the object id map unit
`ifndef OBJECT_ID_MAP_WITH_FRAME_BITMAPS_UNIT_ASSERT_SVH
`define OBJECT_ID_MAP_WITH_FRAME_BITMAPS_UNIT_ASSERT_SVH

// same-cycle implication
`define OIDMAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OIDMAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/oidmap_pkg.sv]
// shared types and constants for the object id map unit
`timescale 1ns / 1ps

package oidmap_pkg;

    localparam int MAX_SLOTS_DEF  = 16;
    localparam int MAX_FRAMES_DEF = 1024;
    localparam int WORD_BITS      = 64;
    localparam int WORD_SHIFT     = 6;

    localparam int ID_W       = 32;
    localparam int SLOT_IN_W  = 4;
    localparam int FRAME_IN_W = 10;
    localparam int FCNT_W     = 11;
    localparam int HELD_W     = 5;

    typedef enum logic [1:0] {
        OP_GET_ADD = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_QUERY   = 2'd2,
        OP_MARK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    add;
        logic    hold_row;
        logic    shift;
        logic    close;
        logic    rd;
        logic    wr;
        logic    fin;
        logic    fin_found;
        logic    fin_bit;
        status_t fin_status;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic at_end;
        logic hit;
        logic full;
        logic last;
        logic acc_ok;
    } dp_stat_t;

endpackage

[hdl/oidmap_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module oidmap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/oidmap_ctrl.sv]
// sequencing state machine for the object id map unit
`timescale 1ns / 1ps

module oidmap_ctrl
    import oidmap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_ACCESS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op inside {OP_GET_ADD, OP_REMOVE})
                begin
                    state_next = S_SCAN;
                end
                else if (stat.acc_ok)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_ACCESS;
                end
                else
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_INVALID;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.at_end)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                    if (stat.op == OP_GET_ADD)
                    begin
                        if (stat.full)
                        begin
                            cmd.fin_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.add        = 1'b1;
                            cmd.fin_found  = 1'b1;
                            cmd.fin_status = ST_OK;
                        end
                    end
                    else
                    begin
                        cmd.fin_status = ST_NOT_FOUND;
                    end
                end
                else if (stat.hit)
                begin
                    if (stat.op == OP_GET_ADD)
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_found  = 1'b1;
                        cmd.fin_status = ST_OK;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.hold_row = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.last)
                begin
                    cmd.close      = 1'b1;
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_ACCESS:
            begin
                cmd.wr         = (stat.op == OP_MARK);
                cmd.fin        = 1'b1;
                cmd.fin_bit    = (stat.op == OP_QUERY);
                cmd.fin_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[hdl/oidmap_dp.sv]
// id table, slot to row map, bitmap ram and result registers
`timescale 1ns / 1ps

module oidmap_dp
    import oidmap_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [FCNT_W-1:0]     cfg_wdata,
    input  logic [1:0]            operation,
    input  logic [ID_W-1:0]       object_id,
    input  logic [SLOT_IN_W-1:0]  slot_index,
    input  logic [FRAME_IN_W-1:0] frame_index,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  done,
    output logic [SLOT_IN_W-1:0]  slot_found,
    output logic                  prompted,
    output logic [1:0]            status,
    output logic [HELD_W-1:0]     objects_held
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int WPR    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int DEPTH  = MAX_SLOTS * WPR;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FCNT_W-1:0]     frame_count_reg;
    op_t                   op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [SLOT_IN_W-1:0]  slot_reg;
    logic [FRAME_IN_W-1:0] frame_reg;

    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] free_row_reg;
    logic [ID_W-1:0]   ids_reg [MAX_SLOTS];
    logic [SLOT_W-1:0] map_reg [MAX_SLOTS];
    logic [WPR-1:0]    vld_reg [MAX_SLOTS];

    logic                 done_reg;
    logic [SLOT_IN_W-1:0] found_reg;
    logic                 prompted_reg;
    status_t              status_reg;
    logic [HELD_W-1:0]    held_reg;

    logic [CNT_W-1:0]      idx_inc;
    logic [SLOT_W-1:0]     idx_lo;
    logic [SLOT_W-1:0]     rd_idx;
    logic [ID_W-1:0]       rd_id;
    logic [SLOT_W-1:0]     rd_row;
    logic [WIDX_W-1:0]     word_idx;
    logic [WORD_SHIFT-1:0] bit_pos;
    logic [ADDR_W-1:0]     ram_addr;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [WORD_BITS-1:0]  word_now;
    logic [WORD_BITS-1:0]  word_wr;
    logic                  old_valid;
    logic                  bit_now;
    logic                  frame_ok;
    logic                  slot_ok;
    logic                  acc_op;

    assign idx_inc = CNT_W'(idx_reg + 1'b1);
    assign idx_lo  = idx_reg[SLOT_W-1:0];
    assign acc_op  = (op_reg == OP_QUERY) || (op_reg == OP_MARK);

    // one shared read port over the id and row tables
    always_comb
    begin
        if (cmd.shift)
        begin
            rd_idx = idx_inc[SLOT_W-1:0];
        end
        else if (acc_op)
        begin
            rd_idx = SLOT_W'(slot_reg);
        end
        else
        begin
            rd_idx = idx_lo;
        end
    end

    assign rd_id  = ids_reg[rd_idx];
    assign rd_row = map_reg[rd_idx];

    assign word_idx = WIDX_W'(frame_reg >> WORD_SHIFT);
    assign bit_pos  = frame_reg[WORD_SHIFT-1:0];
    assign ram_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(WPR) + ADDR_W'(word_idx));

    assign frame_ok = (32'(frame_reg) < 32'(frame_count_reg))
                   && (32'(frame_reg) < 32'(MAX_FRAMES));
    assign slot_ok  = (32'(slot_reg) < 32'(count_reg));

    // words never written since the row was handed out read as zero
    assign old_valid = vld_reg[rd_row][word_idx];
    assign word_now  = old_valid ? ram_rdata : '0;
    assign bit_now   = word_now[bit_pos];
    assign word_wr   = word_now | (WORD_BITS'(1) << bit_pos);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.add)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (cmd.close)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    assign stat.op     = op_reg;
    assign stat.at_end = (idx_reg == count_reg);
    assign stat.hit    = (rd_id == id_reg);
    assign stat.full   = (count_reg == CNT_W'(MAX_SLOTS));
    assign stat.last   = (idx_inc == count_reg);
    assign stat.acc_ok = frame_ok && slot_ok;

    oidmap_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (ram_addr),
        .wdata (word_wr),
        .re    (cmd.rd),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            idx_reg         <= '0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
            for (int k = 0; k < MAX_SLOTS; k++)
            begin
                map_reg[k] <= SLOT_W'(k);
                vld_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                frame_count_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            if (cmd.step || cmd.shift)
            begin
                idx_reg <= idx_inc;
            end
            if (cmd.shift)
            begin
                map_reg[idx_lo] <= rd_row;
            end
            if (cmd.close)
            begin
                map_reg[idx_lo] <= free_row_reg;
            end
            if (cmd.add)
            begin
                vld_reg[rd_row] <= '0;
            end
            if (cmd.wr)
            begin
                vld_reg[rd_row][word_idx] <= 1'b1;
            end
            count_reg <= count_next;
            done_reg  <= cmd.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_t'(operation);
            id_reg    <= object_id;
            slot_reg  <= slot_index;
            frame_reg <= frame_index;
        end
        if (cmd.hold_row)
        begin
            free_row_reg <= rd_row;
        end
        if (cmd.shift)
        begin
            ids_reg[idx_lo] <= rd_id;
        end
        if (cmd.add)
        begin
            ids_reg[idx_lo] <= id_reg;
        end
        if (cmd.fin)
        begin
            found_reg    <= cmd.fin_found ? SLOT_IN_W'(idx_reg) : '0;
            prompted_reg <= cmd.fin_bit & bit_now;
            status_reg   <= cmd.fin_status;
            held_reg     <= HELD_W'(count_next);
        end
    end

    assign done         = done_reg;
    assign slot_found   = found_reg;
    assign prompted     = prompted_reg;
    assign status       = status_reg;
    assign objects_held = held_reg;

endmodule

[hdl/object_id_map_with_frame_bitmaps_unit.sv]
// top level of the object id map with per-slot frame bitmaps
`timescale 1ns / 1ps
`include "object_id_map_with_frame_bitmaps_unit_assert.svh"

// channel   | handshake           | word
// ----------+---------------------+---------------------------------------------
// request   | start, busy         | operation, object_id, slot_index, frame_index
// result    | done (one cycle)    | slot_found, prompted, status, objects_held
// config    | cfg_we              | cfg_wdata (frame count)
//
// get-or-add: the held slots are scanned, one id compared a cycle
// remove: the scan, then one slot moved down a cycle
// query and mark: bitmap word taken by the registered read of the bitmap ram, no ram access if out of range
// reset clears the control state and the per-word bitmap flags, no clearing pass
// a new request may be taken in the cycle its predecessor's done is shown

module object_id_map_with_frame_bitmaps_unit
    import oidmap_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             operation,
    input  logic signed [ID_W-1:0] object_id,
    input  logic [SLOT_IN_W-1:0]   slot_index,
    input  logic [FRAME_IN_W-1:0]  frame_index,
    input  logic                   cfg_we,
    input  logic [FCNT_W-1:0]      cfg_wdata,
    output logic                   done,
    output logic [SLOT_IN_W-1:0]   slot_found,
    output logic                   prompted,
    output logic [1:0]             status,
    output logic [HELD_W-1:0]      objects_held
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    oidmap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    oidmap_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .operation    (operation),
        .object_id    (object_id),
        .slot_index   (slot_index),
        .frame_index  (frame_index),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .slot_found   (slot_found),
        .prompted     (prompted),
        .status       (status),
        .objects_held (objects_held)
    );

    `OIDMAP_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `OIDMAP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request left idle")
    `OIDMAP_ASSERT_NOW(a_full_count, done && (status == ST_FULL),
        32'(objects_held) == MAX_SLOTS, "full reported below capacity")
    `OIDMAP_ASSERT_NOW(a_fail_zero, done && (status != ST_OK),
        (slot_found == '0) && !prompted, "failed request returned data")

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the object id map unit with per-slot frame bitmaps
`timescale 1ns / 1ps

module tb;
    import oidmap_pkg::*;

    localparam int SLOTS       = MAX_SLOTS_DEF;
    localparam int FRAMES      = MAX_FRAMES_DEF;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] slot_found;
        logic                 prompted;
        status_t              status;
        logic [HELD_W-1:0]    objects_held;
    } outcome_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic [1:0]            operation    = '0;
    logic [ID_W-1:0]       object_id    = '0;
    logic [SLOT_IN_W-1:0]  slot_index   = '0;
    logic [FRAME_IN_W-1:0] frame_index  = '0;
    logic                  cfg_we       = 1'b0;
    logic [FCNT_W-1:0]     cfg_wdata    = '0;
    logic                  busy;
    logic                  done;
    logic [SLOT_IN_W-1:0]  slot_found;
    logic                  prompted;
    logic [1:0]            status;
    logic [HELD_W-1:0]     objects_held;

    logic [ID_W-1:0]       id_table [SLOTS];
    logic [FRAMES-1:0]     frame_map [SLOTS];
    int                    held_count  = 0;
    int                    frame_limit = 0;
    outcome_t              pending_outcomes [$];
    int                    mismatches  = 0;
    int                    idle_pct    = 0;
    int                    cycle_count = 0;
    logic [ID_W-1:0]       id_pool [POOL_SIZE];
    logic [FRAME_IN_W-1:0] hot_frames [8];

    object_id_map_with_frame_bitmaps_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .object_id    (object_id),
        .slot_index   (slot_index),
        .frame_index  (frame_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .slot_found   (slot_found),
        .prompted     (prompted),
        .status       (status),
        .objects_held (objects_held)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic outcome_t map_apply(op_t op, logic [ID_W-1:0] id,
                                           logic [SLOT_IN_W-1:0] slot,
                                           logic [FRAME_IN_W-1:0] frame);
        outcome_t res;
        int       i;
        int       pos;
        res        = '0;
        res.status = ST_OK;
        pos        = -1;
        for (i = 0; i < held_count; i++)
        begin
            if (pos < 0 && id_table[i] == id)
                pos = i;
        end
        case (op)
            OP_GET_ADD:
            begin
                if (pos >= 0)
                    res.slot_found = SLOT_IN_W'(pos);
                else if (held_count >= SLOTS)
                    res.status = ST_FULL;
                else
                begin
                    id_table[held_count]  = id;
                    frame_map[held_count] = '0;
                    res.slot_found        = SLOT_IN_W'(held_count);
                    held_count++;
                end
            end
            OP_REMOVE:
            begin
                if (pos < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (i = pos; i < held_count - 1; i++)
                    begin
                        id_table[i]  = id_table[i + 1];
                        frame_map[i] = frame_map[i + 1];
                    end
                    held_count--;
                    id_table[held_count]  = '0;
                    frame_map[held_count] = '0;
                end
            end
            default:
            begin
                if (int'(slot) >= held_count || int'(frame) >= frame_limit
                    || int'(frame) >= FRAMES)
                    res.status = ST_INVALID;
                else if (op == OP_QUERY)
                    res.prompted = frame_map[slot][frame];
                else
                    frame_map[slot][frame] = 1'b1;
            end
        endcase
        res.objects_held = HELD_W'(held_count);
        return res;
    endfunction

    function automatic logic [ID_W-1:0] edge_id(int n);
        case (n)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h5A5A_0000 + ID_W'(n);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result word with nothing pending");
            else
            begin
                want = pending_outcomes.pop_front();
                if (slot_found !== want.slot_found)
                    report_mismatch($sformatf("slot_found %0d, wanted %0d",
                                              slot_found, want.slot_found));
                if (prompted !== want.prompted)
                    report_mismatch($sformatf("prompted %0b, wanted %0b",
                                              prompted, want.prompted));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              status, want.status));
                if (objects_held !== want.objects_held)
                    report_mismatch($sformatf("objects_held %0d, wanted %0d",
                                              objects_held, want.objects_held));
            end
        end
    end

    task automatic send_word(op_t op, logic [ID_W-1:0] id,
                             logic [SLOT_IN_W-1:0] slot, logic [FRAME_IN_W-1:0] frame);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= op;
        object_id   <= id;
        slot_index  <= slot;
        frame_index <= frame;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_outcomes.push_back(map_apply(op, id, slot, frame));
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_count(int unsigned value);
        cfg_wdata <= FCNT_W'(value);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        frame_limit = int'(value & 32'h7FF);
        @(posedge clk);
    endtask

    task automatic pick_hot_frames();
        int i;
        int span;
        span = (frame_limit < FRAMES) ? frame_limit : FRAMES;
        for (i = 0; i < 8; i++)
            hot_frames[i] = (span > 0) ? FRAME_IN_W'($urandom_range(span - 1))
                                       : FRAME_IN_W'($urandom_range(FRAMES - 1));
    endtask

    task automatic test_power_up();
        // empty table, frame count still zero
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd0);
        send_word(OP_REMOVE, 32'h0000_1234, 4'd0, 10'd0);
        send_word(OP_MARK, 32'h0, 4'd15, 10'd1023);
        wait_quiet();
        write_frame_count(FRAMES);
    endtask

    task automatic test_table_edges();
        int i;
        for (i = 0; i < SLOTS; i++)
            send_word(OP_GET_ADD, edge_id(i), 4'(15 - i), 10'(i * 67));
        send_word(OP_GET_ADD, edge_id(1), 4'd9, 10'd511);
        send_word(OP_GET_ADD, 32'h0BAD_F00D, 4'd0, 10'd0);
        send_word(OP_MARK, 32'hFFFF_FFFF, 4'd15, 10'd1023);
        send_word(OP_MARK, 32'h0, 4'd4, 10'd0);
        send_word(OP_QUERY, 32'h0, 4'd15, 10'd1023);
        // removal moves later slots and their bitmaps down
        send_word(OP_REMOVE, edge_id(3), 4'd0, 10'd0);
        send_word(OP_QUERY, 32'h0, 4'd14, 10'd1023);
        send_word(OP_QUERY, 32'h0, 4'd3, 10'd0);
        send_word(OP_QUERY, 32'h0, 4'd15, 10'd0);
        send_word(OP_REMOVE, edge_id(3), 4'd15, 10'd1023);
        // re-added id gets a cleared bitmap
        send_word(OP_GET_ADD, edge_id(3), 4'd0, 10'd0);
        send_word(OP_QUERY, 32'h0, 4'd15, 10'd1023);
        wait_quiet();
    endtask

    task automatic test_frame_limits();
        write_frame_count(8);
        send_word(OP_MARK, 32'h0, 4'd0, 10'd7);
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd8);
        send_word(OP_MARK, 32'h0, 4'd0, 10'd8);
        wait_quiet();
        write_frame_count(FRAMES);
        send_word(OP_MARK, 32'h0, 4'd0, 10'd1000);
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd8);
        wait_quiet();
        write_frame_count(0);
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd0);
        wait_quiet();
        // bits above a lowered limit stay stored
        write_frame_count(8);
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd1000);
        wait_quiet();
        write_frame_count(2047);
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd1000);
        send_word(OP_QUERY, 32'h0, 4'd0, 10'd7);
        wait_quiet();
    endtask

    task automatic test_random_traffic(int pct, int unsigned limit_a,
                                       int unsigned limit_b, int count);
        int                    n;
        int                    r;
        int                    span;
        op_t                   op;
        logic [ID_W-1:0]       id;
        logic [SLOT_IN_W-1:0]  slot;
        logic [FRAME_IN_W-1:0] frame;
        idle_pct = pct;
        write_frame_count(limit_a);
        pick_hot_frames();
        for (n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                // hold off until the pipeline has drained
                wait_quiet();
                write_frame_count(limit_b);
                pick_hot_frames();
            end
            r = $urandom_range(99);
            if (r < 30 + ((held_count < 4) ? 15 : 0))
                op = OP_GET_ADD;
            else if (r < 50)
                op = OP_REMOVE;
            else if (r < 75)
                op = OP_QUERY;
            else
                op = OP_MARK;
            if ($urandom_range(99) < 85)
                id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else
                id = $urandom();
            if ($urandom_range(99) < 80 && held_count > 0)
                slot = SLOT_IN_W'($urandom_range(held_count - 1));
            else
                slot = SLOT_IN_W'($urandom_range(SLOTS - 1));
            span = (frame_limit < FRAMES) ? frame_limit : FRAMES;
            r    = $urandom_range(99);
            if (r < 45)
                frame = hot_frames[$urandom_range(7)];
            else if (r < 80 && span > 0)
                frame = FRAME_IN_W'($urandom_range(span - 1));
            else
                frame = FRAME_IN_W'($urandom_range(FRAMES - 1));
            send_word(op, id, slot, frame);
        end
        wait_quiet();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            id_table[i]  = '0;
            frame_map[i] = '0;
        end
        for (i = 0; i < POOL_SIZE; i++)
            id_pool[i] = (i < SLOTS) ? edge_id(i) : ID_W'($urandom());
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_table_edges();
        test_frame_limits();
        test_random_traffic(26, FRAMES, $urandom_range(1, FRAMES - 1), 410);
        test_random_traffic(56, 2047, 1, 410);
        test_random_traffic(0, $urandom_range(16, FRAMES - 1), FRAMES, 410);

        wait_quiet();
        repeat (40) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_outcomes.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/oidmap_pkg.sv
hdl/oidmap_ram.sv
hdl/oidmap_ctrl.sv
hdl/oidmap_dp.sv
hdl/object_id_map_with_frame_bitmaps_unit.sv
tb/sv/tb.sv
